/* rtl/assert_macros.svh */
// assertion macros shared by the date advance rtl
// no dependencies; included by the modules that carry checks
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// consequent must hold in the same cycle as the antecedent
`define CDA_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("%m: check failed");

// consequent must hold in the cycle after the antecedent
`define CDA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("%m: check failed");

`endif

/* rtl/cda_pkg.sv */
// types, constants and calendar functions for the date advance block
// no dependencies; used by cda_dp, cda_ctrl and calendar_date_advance
package cda_pkg;

	typedef struct packed {
		logic        op;
		logic [3:0]  month_in;
		logic [4:0]  day_in;
		logic [13:0] year_in;
		logic [15:0] add_days;
	} item_in_t;

	typedef struct packed {
		logic [3:0]  month_out;
		logic [4:0]  day_out;
		logic [13:0] year_out;
		logic [8:0]  day_of_year;
		logic [8:0]  days_left;
		logic [1:0]  status;
	} item_out_t;

	// controller to datapath
	typedef struct packed {
		logic capture;
		logic ld_leap;
		logic ld_check;
		logic adv_start;
		logic year_step;
		logic month_step;
		logic emit;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic op;
		logic year_more;
		logic year_over;
		logic month_more;
		logic out_free;
	} sts_t;

	localparam logic OP_LOAD    = 1'b0;
	localparam logic OP_ADVANCE = 1'b1;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_REJECT   = 2'd1;
	localparam logic [1:0] ST_OVERFLOW = 2'd2;

	localparam logic [13:0] BASE_YEAR = 14'd1900;
	localparam logic [3:0]  JAN       = 4'd1;
	localparam logic [3:0]  FEB       = 4'd2;
	localparam logic [3:0]  DEC       = 4'd12;

	// 25 * 7209 = 1 mod 2^14, so y is a multiple of 25 iff y * 7209 mod 2^14 <= 16383 / 25
	localparam logic [13:0] INV25       = 14'd7209;
	localparam logic [13:0] DIV25_LIMIT = 14'd655;

	function automatic logic is_leap(input logic [13:0] y);
		logic [27:0] prod;
		logic        div25;
		prod  = 28'(y) * 28'(INV25);
		div25 = (prod[13:0] <= DIV25_LIMIT);
		// div by 4, and not by 100 unless by 400
		return (y[1:0] == 2'b00) && (!div25 || (y[3:0] == 4'b0000));
	endfunction

	function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
		logic [4:0] len;
		if (m == FEB) begin
			len = leap ? 5'd29 : 5'd28;
		end else if (m inside {4'd4, 4'd6, 4'd9, 4'd11}) begin
			len = 5'd30;
		end else begin
			len = 5'd31;
		end
		return len;
	endfunction

	function automatic logic [8:0] days_before(input logic [3:0] m, input logic leap);
		logic [8:0] base;
		case (m)
			4'd1:    base = 9'd0;
			4'd2:    base = 9'd31;
			4'd3:    base = 9'd59;
			4'd4:    base = 9'd90;
			4'd5:    base = 9'd120;
			4'd6:    base = 9'd151;
			4'd7:    base = 9'd181;
			4'd8:    base = 9'd212;
			4'd9:    base = 9'd243;
			4'd10:   base = 9'd273;
			4'd11:   base = 9'd304;
			4'd12:   base = 9'd334;
			default: base = 9'd0;
		endcase
		if (leap && (m > FEB)) begin
			base = base + 9'd1;
		end
		return base;
	endfunction

	function automatic logic [8:0] year_len(input logic leap);
		return leap ? 9'd366 : 9'd365;
	endfunction

endpackage

/* rtl/cda_dp.sv */
// datapath: held date, input capture, year and month walk, result register
// depends on cda_pkg; driven by cda_ctrl through cda_pkg::cmd_t
module cda_dp #(
	parameter int MAX_YEAR = 9999
) (
	input  logic               clk,
	input  logic               arst_n,
	input  cda_pkg::item_in_t  item,
	input  cda_pkg::cmd_t      cmd,
	output cda_pkg::sts_t      sts,
	output cda_pkg::item_out_t result,
	output logic               result_valid,
	input  logic               result_stall
);

	cda_pkg::item_in_t  in_q;
	cda_pkg::item_out_t result_q;
	logic               result_valid_q;

	logic [3:0]  cur_month_q;
	logic [4:0]  cur_day_q;
	logic [13:0] cur_year_q;
	logic        cur_leap_q;

	logic        leap_in_q;
	logic [16:0] total_q;
	logic [13:0] year_q;
	logic        leap_q;
	logic [3:0]  month_q;
	logic [1:0]  status_q;

	logic [8:0]  ylen;
	logic [4:0]  mlen;
	logic [14:0] year_next;
	logic        leap_next;
	logic        year_more;
	logic        year_over;
	logic        month_more;
	logic        load_ok;
	logic [16:0] start_total;
	logic [8:0]  doy;
	logic [8:0]  left;

	assign ylen       = cda_pkg::year_len(leap_q);
	assign mlen       = cda_pkg::month_len(month_q, leap_q);
	assign year_next  = {1'b0, year_q} + 15'd1;
	assign leap_next  = cda_pkg::is_leap(year_next[13:0]);
	assign year_more  = total_q > {8'd0, ylen};
	assign year_over  = year_next > 15'(MAX_YEAR);
	assign month_more = (month_q < cda_pkg::DEC) && (total_q > {12'd0, mlen});

	assign load_ok = (in_q.year_in >= cda_pkg::BASE_YEAR) &&
		(in_q.year_in <= 14'(MAX_YEAR)) &&
		(in_q.month_in >= cda_pkg::JAN) && (in_q.month_in <= cda_pkg::DEC) &&
		(in_q.day_in >= 5'd1) &&
		(in_q.day_in <= cda_pkg::month_len(in_q.month_in, leap_in_q));

	assign start_total = 17'(cda_pkg::days_before(cur_month_q, cur_leap_q)) +
		17'(cur_day_q) + 17'(in_q.add_days);

	assign doy  = cda_pkg::days_before(cur_month_q, cur_leap_q) + 9'(cur_day_q);
	assign left = cda_pkg::year_len(cur_leap_q) - doy;

	assign sts.op         = item.op;
	assign sts.year_more  = year_more;
	assign sts.year_over  = year_over;
	assign sts.month_more = month_more;
	assign sts.out_free   = !result_valid_q || !result_stall;

	assign result       = result_q;
	assign result_valid = result_valid_q;

	// held date and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_month_q    <= cda_pkg::JAN;
			cur_day_q      <= 5'd1;
			cur_year_q     <= cda_pkg::BASE_YEAR;
			cur_leap_q     <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			if (cmd.ld_check && load_ok) begin
				cur_month_q <= in_q.month_in;
				cur_day_q   <= in_q.day_in;
				cur_year_q  <= in_q.year_in;
				cur_leap_q  <= leap_in_q;
			end
			if (cmd.month_step && !month_more) begin
				// leftover count is the new day of month
				cur_month_q <= month_q;
				cur_day_q   <= total_q[4:0];
				cur_year_q  <= year_q;
				cur_leap_q  <= leap_q;
			end
			if (cmd.emit) begin
				result_valid_q <= 1'b1;
			end else if (!result_stall) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			in_q <= item;
		end
		if (cmd.ld_leap) begin
			leap_in_q <= cda_pkg::is_leap(in_q.year_in);
		end
		if (cmd.ld_check) begin
			status_q <= load_ok ? cda_pkg::ST_OK : cda_pkg::ST_REJECT;
		end
		if (cmd.adv_start) begin
			total_q <= start_total;
			year_q  <= cur_year_q;
			leap_q  <= cur_leap_q;
			month_q <= cda_pkg::JAN;
		end
		if (cmd.year_step && year_more) begin
			total_q <= total_q - {8'd0, ylen};
			year_q  <= year_next[13:0];
			leap_q  <= leap_next;
			if (year_over) begin
				status_q <= cda_pkg::ST_OVERFLOW;
			end
		end
		if (cmd.month_step) begin
			if (month_more) begin
				total_q <= total_q - {12'd0, mlen};
				month_q <= month_q + 4'd1;
			end else begin
				status_q <= cda_pkg::ST_OK;
			end
		end
		if (cmd.emit) begin
			result_q.month_out   <= cur_month_q;
			result_q.day_out     <= cur_day_q;
			result_q.year_out    <= cur_year_q;
			result_q.day_of_year <= doy;
			result_q.days_left   <= left;
			result_q.status      <= status_q;
		end
	end

endmodule

/* rtl/cda_ctrl.sv */
// controller state machine for the date advance block
// depends on cda_pkg and assert_macros.svh; commands cda_dp
`include "assert_macros.svh"

module cda_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          item_valid,
	output logic          item_stall,
	output cda_pkg::cmd_t cmd,
	input  cda_pkg::sts_t sts
);

	localparam logic [2:0] S_IDLE      = 3'd0;
	localparam logic [2:0] S_LD_LEAP   = 3'd1;
	localparam logic [2:0] S_LD_CHECK  = 3'd2;
	localparam logic [2:0] S_ADV_START = 3'd3;
	localparam logic [2:0] S_YEAR      = 3'd4;
	localparam logic [2:0] S_MONTH     = 3'd5;
	localparam logic [2:0] S_DONE      = 3'd6;

	logic [2:0] state_q;
	logic [2:0] state_d;

	assign item_stall = (state_q != S_IDLE);

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			S_IDLE: begin
				if (item_valid) begin
					cmd.capture = 1'b1;
					state_d = (sts.op == cda_pkg::OP_LOAD) ? S_LD_LEAP : S_ADV_START;
				end
			end
			S_LD_LEAP: begin
				cmd.ld_leap = 1'b1;
				state_d = S_LD_CHECK;
			end
			S_LD_CHECK: begin
				cmd.ld_check = 1'b1;
				state_d = S_DONE;
			end
			S_ADV_START: begin
				cmd.adv_start = 1'b1;
				state_d = S_YEAR;
			end
			S_YEAR: begin
				cmd.year_step = 1'b1;
				if (!sts.year_more) begin
					state_d = S_MONTH;
				end else if (sts.year_over) begin
					state_d = S_DONE;
				end
			end
			S_MONTH: begin
				cmd.month_step = 1'b1;
				if (!sts.month_more) begin
					state_d = S_DONE;
				end
			end
			S_DONE: begin
				// wait for room in the result register
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	`CDA_ASSERT_NEXT(a_accept_starts, clk, arst_n, item_valid && !item_stall, state_q == S_LD_LEAP || state_q == S_ADV_START)
	`CDA_ASSERT_NOW(a_emit_has_room, clk, arst_n, cmd.emit, sts.out_free)
	`CDA_ASSERT_NEXT(a_overflow_ends_walk, clk, arst_n, state_q == S_YEAR && sts.year_more && sts.year_over, state_q == S_DONE)

endmodule

/* rtl/calendar_date_advance.sv */
// Holds one Gregorian date (reset 1 January 1900) and answers every transaction with
// exactly one result: the date after the step, its day of year and the days left in
// the year. A load sets the date only when month, day and year (1900 to MAX_YEAR)
// form a valid date, else status 1. An advance adds add_days by walking whole years,
// then months, one per cycle in the datapath's subtract loop; a walk past MAX_YEAR
// leaves the date as it was with status 2. At most 11 months are walked in the final
// year. One transaction is in progress at a time; the result register lets the next
// transaction be accepted while the previous result is still waiting.
// top level; depends on cda_pkg, cda_ctrl and cda_dp
module calendar_date_advance #(
	parameter int MAX_YEAR = 9999
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               item_valid,
	output logic               item_stall,
	input  cda_pkg::item_in_t  item,
	output logic               result_valid,
	input  logic               result_stall,
	output cda_pkg::item_out_t result
);

	cda_pkg::cmd_t cmd;
	cda_pkg::sts_t sts;

	cda_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.cmd        (cmd),
		.sts        (sts)
	);

	cda_dp #(
		.MAX_YEAR (MAX_YEAR)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.item         (item),
		.cmd          (cmd),
		.sts          (sts),
		.result       (result),
		.result_valid (result_valid),
		.result_stall (result_stall)
	);

endmodule

/* tb/sv/date_advance_checker.sv */
// transaction checker for calendar_date_advance: keeps its own copy of the date,
// predicts one result per accepted input transaction and compares it field by field
// depends on cda_pkg for the payload types and status and operation codes
`timescale 1ns / 100ps

module date_advance_checker #(
	parameter int MAX_YEAR = 9999
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               item_valid,
	input  logic               item_stall,
	input  cda_pkg::item_in_t  item,
	input  logic               result_valid,
	input  logic               result_stall,
	input  cda_pkg::item_out_t result,
	output int                 fail_count,
	output int                 outstanding,
	output int                 results_checked,
	output int                 rejects_seen,
	output int                 overflows_seen
);
	import cda_pkg::*;

	logic [3:0]  date_month;
	logic [4:0]  date_day;
	logic [13:0] date_year;
	item_out_t   expected_dates[$];
	int          mismatches;
	int          checked;
	int          rejects;
	int          overflows;

	function automatic bit is_leap_year(input int y);
		return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
	endfunction

	function automatic int days_in_month(input int m, input int y);
		if (m == FEB) begin
			return is_leap_year(y) ? 29 : 28;
		end
		if (m inside {4, 6, 9, 11}) begin
			return 30;
		end
		return 31;
	endfunction

	function automatic int year_days(input int y);
		return is_leap_year(y) ? 366 : 365;
	endfunction

	function automatic int day_number(input int m, input int d, input int y);
		int total;
		total = d;
		for (int k = JAN; k < m; k++) begin
			total += days_in_month(k, y);
		end
		return total;
	endfunction

	// updates the held date and returns the result the block should give
	function automatic item_out_t next_calendar_date(input item_in_t it);
		item_out_t r;
		int        total;
		int        y;
		int        m;
		bit        over;
		int        doy;
		r = '0;
		r.status = ST_OK;
		if (it.op == OP_LOAD) begin
			if (it.year_in >= BASE_YEAR && it.year_in <= MAX_YEAR &&
			    it.month_in >= JAN && it.month_in <= DEC && it.day_in >= 1 &&
			    it.day_in <= days_in_month(it.month_in, it.year_in)) begin
				date_month = it.month_in;
				date_day   = it.day_in;
				date_year  = it.year_in;
			end else begin
				r.status = ST_REJECT;
			end
		end else begin
			// count from 1 january of the current year, then strip whole years and months
			total = day_number(date_month, date_day, date_year) + it.add_days;
			y     = date_year;
			over  = 1'b0;
			while (!over && total > year_days(y)) begin
				total -= year_days(y);
				y++;
				if (y > MAX_YEAR) begin
					over = 1'b1;
				end
			end
			if (over) begin
				r.status = ST_OVERFLOW;
			end else begin
				m = JAN;
				while (m < DEC && total > days_in_month(m, y)) begin
					total -= days_in_month(m, y);
					m++;
				end
				date_year  = 14'(y);
				date_month = 4'(m);
				date_day   = 5'(total);
			end
		end
		doy = day_number(date_month, date_day, date_year);
		r.month_out   = date_month;
		r.day_out     = date_day;
		r.year_out    = date_year;
		r.day_of_year = 9'(doy);
		r.days_left   = 9'(year_days(date_year) - doy);
		return r;
	endfunction

	task automatic check_field(input string field, input int want, input int got);
		if (want != got) begin
			$error("%s mismatch: expected %0d, actual %0d", field, want, got);
			mismatches++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		item_out_t want;
		if (!arst_n) begin
			date_month = JAN;
			date_day   = 5'd1;
			date_year  = BASE_YEAR;
		end else begin
			if (result_valid && !result_stall) begin
				if (expected_dates.size() == 0) begin
					$error("result transaction with no expected date waiting");
					mismatches++;
				end else begin
					want = expected_dates.pop_front();
					check_field("month_out", want.month_out, result.month_out);
					check_field("day_out", want.day_out, result.day_out);
					check_field("year_out", want.year_out, result.year_out);
					check_field("day_of_year", want.day_of_year, result.day_of_year);
					check_field("days_left", want.days_left, result.days_left);
					check_field("status", want.status, result.status);
					checked++;
				end
			end
			if (item_valid && !item_stall) begin
				want = next_calendar_date(item);
				if (want.status == ST_REJECT) begin
					rejects++;
				end
				if (want.status == ST_OVERFLOW) begin
					overflows++;
				end
				expected_dates.push_back(want);
			end
		end
		fail_count      <= mismatches;
		outstanding     <= expected_dates.size();
		results_checked <= checked;
		rejects_seen    <= rejects;
		overflows_seen  <= overflows;
	end

endmodule

/* tb/sv/calendar_date_advance_test.sv */
// top of the calendar_date_advance testbench: clock, reset, stimulus and verdict
// depends on cda_pkg, calendar_date_advance and date_advance_checker
`timescale 1ns / 100ps

module calendar_date_advance_test;
	import cda_pkg::*;

	localparam int MAX_YEAR     = 9999;
	localparam int RANDOM_ITEMS = 1228;
	localparam int HOLD_CYCLES  = 400;
	localparam int IDLE_LIMIT   = 4000;
	localparam int DRAIN_CYCLES = 250;

	logic      clk = 1'b0;
	logic      arst_n;
	logic      item_valid;
	logic      item_stall;
	item_in_t  item;
	logic      result_valid;
	logic      result_stall;
	item_out_t result;

	int fail_count;
	int outstanding;
	int results_checked;
	int rejects_seen;
	int overflows_seen;

	int sender_idle_pct;
	int stall_pct;
	bit hold_request;
	bit hold_done;
	int items_sent;
	int idle_cycles;

	always #5 clk = ~clk;

	calendar_date_advance #(
		.MAX_YEAR(MAX_YEAR)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.item(item),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result(result)
	);

	date_advance_checker #(
		.MAX_YEAR(MAX_YEAR)
	) checker_i (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.item(item),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result(result),
		.fail_count(fail_count),
		.outstanding(outstanding),
		.results_checked(results_checked),
		.rejects_seen(rejects_seen),
		.overflows_seen(overflows_seen)
	);

	// fields the operation does not use are filled with noise
	function automatic item_in_t load_item(input int m, input int d, input int y);
		item_in_t it;
		it.op       = OP_LOAD;
		it.month_in = 4'(m);
		it.day_in   = 5'(d);
		it.year_in  = 14'(y);
		it.add_days = 16'($urandom);
		return it;
	endfunction

	function automatic item_in_t advance_item(input int n);
		item_in_t it;
		it.op       = OP_ADVANCE;
		it.month_in = 4'($urandom);
		it.day_in   = 5'($urandom);
		it.year_in  = 14'($urandom);
		it.add_days = 16'(n);
		return it;
	endfunction

	function automatic item_in_t pick_random_item();
		int sel;
		int y;
		int d;
		int n;
		sel = $urandom_range(99);
		if (sel < 30) begin
			// mostly well-formed loads, some near century and year-limit boundaries
			if ($urandom_range(9) == 0) begin
				case ($urandom_range(4))
					0:       y = 1900;
					1:       y = 2000;
					2:       y = 2100;
					3:       y = 2400;
					default: y = MAX_YEAR - $urandom_range(3);
				endcase
			end else begin
				y = $urandom_range(MAX_YEAR, BASE_YEAR);
			end
			d = ($urandom_range(9) < 8) ? $urandom_range(28, 1) : $urandom_range(31, 29);
			return load_item($urandom_range(DEC, JAN), d, y);
		end
		if (sel < 38) begin
			return load_item($urandom_range(15), $urandom_range(31), $urandom_range(16383));
		end
		sel = $urandom_range(99);
		if (sel < 5) begin
			n = 0;
		end else if (sel < 45) begin
			n = $urandom_range(400);
		end else if (sel < 75) begin
			n = $urandom_range(4000);
		end else if (sel < 92) begin
			n = $urandom_range(20000);
		end else begin
			n = $urandom_range(65535);
		end
		return advance_item(n);
	endfunction

	task automatic send_item(input item_in_t it);
		while ($urandom_range(99) < sender_idle_pct) begin
			item_valid <= 1'b0;
			@(posedge clk);
		end
		item       <= it;
		item_valid <= 1'b1;
		do @(posedge clk); while (item_stall);
		items_sent++;
	endtask

	task automatic wait_for_drain();
		item_valid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
	endtask

	// result side: random stalls, plus one long hold-off to back the block up
	initial begin
		result_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_request && !hold_done) begin
				result_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_done = 1'b1;
				result_stall <= 1'b0;
			end else begin
				result_stall <= ($urandom_range(99) < stall_pct);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((item_valid && !item_stall) || (result_valid && !result_stall)) begin
				idle_cycles <= 0;
			end else if (idle_cycles >= IDLE_LIMIT) begin
				$display("no transaction for %0d cycles", IDLE_LIMIT);
				$display("CHECK FAILED");
				$finish;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
		end
	end

	initial begin
		int sender_phase[4];
		int stall_phase[4];
		sender_phase = '{0, 71, 0, 27};
		stall_phase  = '{0, 0, 71, 27};
		sender_idle_pct = 0;
		stall_pct       = 0;
		hold_request    = 1'b0;
		hold_done       = 1'b0;
		items_sent      = 0;
		idle_cycles     = 0;
		arst_n     <= 1'b0;
		item_valid <= 1'b0;
		item       <= '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: zero advance from reset, century leap rules, bad fields, year limit
		send_item(advance_item(0));
		send_item(load_item(2, 29, 1900));
		send_item(load_item(2, 29, 2000));
		send_item(advance_item(366));
		send_item(load_item(0, 0, 0));
		send_item(load_item(13, 1, 2000));
		send_item(load_item(15, 31, 16383));
		send_item(load_item(4, 31, 2001));
		send_item(load_item(6, 0, 2001));
		send_item(load_item(1, 1, 1899));
		send_item(load_item(1, 1, MAX_YEAR + 1));
		send_item(load_item(1, 1, 1900));
		send_item(advance_item(65535));
		send_item(load_item(2, 29, 2024));
		send_item(load_item(2, 28, 2100));
		send_item(advance_item(1));
		send_item(load_item(12, 31, 2099));
		send_item(advance_item(1));
		send_item(load_item(12, 31, MAX_YEAR));
		send_item(advance_item(0));
		send_item(advance_item(1));
		send_item(load_item(1, 1, MAX_YEAR));
		send_item(advance_item(364));
		send_item(advance_item(65535));
		wait_for_drain();

		for (int p = 0; p < 4; p++) begin
			sender_idle_pct = sender_phase[p];
			stall_pct       = stall_phase[p];
			if (p == 0) begin
				hold_request = 1'b1;
			end
			for (int k = 0; k < RANDOM_ITEMS / 4; k++) begin
				send_item(pick_random_item());
			end
			if (p == 1) begin
				wait_for_drain();
			end
		end

		wait_for_drain();
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("%0d transactions sent, %0d results compared", items_sent, results_checked);
		$display("%0d loads rejected, %0d advances past the year limit",
			rejects_seen, overflows_seen);
		if (fail_count == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule
